// ----- src/bitmap_font_text_layout_assert.svh -----
// Assertion macros for the bitmap font text layout block
`ifndef BITMAP_FONT_TEXT_LAYOUT_ASSERT_SVH
`define BITMAP_FONT_TEXT_LAYOUT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BFL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bitmap font text layout: same-cycle check failed");

// next-cycle implication, checked outside reset
`define BFL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bitmap font text layout: next-cycle check failed");

`endif

// ----- src/bfl_pkg.sv -----
// Types, codes and helpers shared by the bitmap font text layout block
package bfl_pkg;

    localparam logic [7:0]  CODE_SPACE   = 8'd32;
    localparam logic [7:0]  CODE_NEWLINE = 8'd10;
    localparam logic [7:0]  CODE_TAB     = 8'd9;
    localparam logic [14:0] PEN_MAX      = 15'h7FFF;

    localparam logic [9:0]  SPACE_WIDTH_RST = 10'd10;
    localparam logic [3:0]  TAB_SIZE_RST    = 4'd4;

    localparam logic [1:0]  CFG_LINE_HEIGHT = 2'd0;
    localparam logic [1:0]  CFG_TAB_SIZE    = 2'd1;
    localparam logic [1:0]  CFG_MAX_LINE    = 2'd2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LAYOUT = 1'b1;

    typedef struct packed {
        logic [11:0] sx;
        logic [11:0] sy;
        logic [9:0]  w;
        logic [9:0]  h;
    } rect_t;

    typedef struct packed {
        logic signed [9:0] xoff;
        logic signed [9:0] yoff;
        logic [9:0]        adv;
        logic [3:0]        page;
    } metric_t;

    typedef struct packed {
        logic mode;
        logic first;
        logic newline;
        logic tab;
        logic space;
        logic hit;
    } lookup_t;

    function automatic logic [14:0] sat_pen(input logic [15:0] s);
        return s[15] ? PEN_MAX : s[14:0];
    endfunction

endpackage

// ----- src/bitmap_font_text_layout.sv -----
// Bitmap font text layout: glyph table, running pen and draw rectangle output
//
// Input stream (s_*): one transaction per item. s_tuser[0] selects the kind
// (0 loads a glyph entry, 1 lays out one character), s_tuser[1] starts a new
// text. Every input transaction yields exactly one output transaction on m_*,
// carrying the draw rectangle (m_tuser[0] high when a glyph is drawn) and the
// pen after the item.
// Configuration (cfg_*): register writes; the user must write only while the block
// is idle, as cfg_ready is tied high. Throughput: one item per cycle while the
// receiver does not stall; each item passes the lookup stage, then the output
// register, which drives m_tvalid. The glyph memories have a registered read,
// and the pen is updated from the read data as the item leaves the lookup stage.
// Reset clears the glyph valid bits, the pen, the line height and maximum line
// registers and sets the space width (10) and the tab size (4); glyph rectangles
// stay unknown until loaded. When the receiver stalls, the output register holds
// its transaction and one more item waits in the lookup stage; s_tready then drops.
`include "bitmap_font_text_layout_assert.svh"

module bitmap_font_text_layout #(
    parameter int GLYPH_COUNT = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // char_code[7:0], glyph_src_x[19:8], glyph_src_y[31:20], glyph_width[41:32],
    // glyph_height[51:42], glyph_x_offset[61:52], glyph_y_offset[71:62],
    // glyph_advance[81:72], glyph_page[85:82], zero pad[87:86]
    input  logic [87:0]  s_tdata,
    // mode[0], first_of_text[1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dest_x[16:0], dest_y[33:17], src_x[45:34], src_y[57:46], rect_width[67:58],
    // rect_height[77:68], page[81:78], pen_x[96:82], pen_y[111:97]
    output logic [111:0] m_tdata,
    // draw[0]
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [14:0]  cfg_data
);
    import bfl_pkg::*;

    localparam int AW = $clog2(GLYPH_COUNT);

    // configuration
    logic [9:0]  line_height_reg;
    logic [3:0]  tab_size_reg;
    logic [14:0] max_line_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_height_reg <= '0;
            tab_size_reg    <= TAB_SIZE_RST;
            max_line_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LINE_HEIGHT: line_height_reg <= cfg_data[9:0];
                CFG_TAB_SIZE:    tab_size_reg    <= cfg_data[3:0];
                CFG_MAX_LINE:    max_line_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input decode
    logic       s_acc;
    logic       in_mode;
    logic [7:0] in_code;
    logic       in_nl;
    logic       in_tab;
    logic [7:0] map_code;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    rect_t      in_rect;
    metric_t    in_metric;

    assign s_acc    = s_tvalid && s_tready;
    assign in_mode  = s_tuser[0];
    assign in_code  = s_tdata[7:0];
    assign in_nl    = (in_code == CODE_NEWLINE);
    assign in_tab   = (in_code == CODE_TAB);
    assign map_code = ((in_code < CODE_SPACE) || in_code[7]) ? CODE_SPACE : in_code;
    assign wr_en    = s_acc && (in_mode == MODE_LOAD) && ({1'b0, in_code} < 9'(GLYPH_COUNT));
    assign wr_addr  = in_code[AW-1:0];
    assign rd_addr  = map_code[AW-1:0];

    assign in_rect.sx      = s_tdata[19:8];
    assign in_rect.sy      = s_tdata[31:20];
    assign in_rect.w       = s_tdata[41:32];
    assign in_rect.h       = s_tdata[51:42];
    assign in_metric.xoff  = s_tdata[61:52];
    assign in_metric.yoff  = s_tdata[71:62];
    assign in_metric.adv   = s_tdata[81:72];
    assign in_metric.page  = s_tdata[85:82];

    // glyph memories, one write and one registered read port each
    rect_t   rect_mem   [GLYPH_COUNT];
    metric_t metric_mem [GLYPH_COUNT];
    rect_t   rect_rd_reg;
    metric_t metric_rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rect_mem[wr_addr]   <= in_rect;
            metric_mem[wr_addr] <= in_metric;
        end
        if (s_acc) begin
            rect_rd_reg   <= rect_mem[rd_addr];
            metric_rd_reg <= metric_mem[rd_addr];
        end
    end

    logic [GLYPH_COUNT-1:0] glyph_valid_reg;
    logic [9:0]             space_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_valid_reg <= '0;
            space_width_reg <= SPACE_WIDTH_RST;
        end else if (wr_en) begin
            glyph_valid_reg[wr_addr] <= 1'b1;
            if (in_code == CODE_SPACE) begin
                space_width_reg <= in_metric.adv;
            end
        end
    end

    // lookup stage and output register handshake
    logic    s1_valid_reg;
    logic    s1_valid_next;
    lookup_t s1_reg;
    lookup_t s1_next;
    logic    m_tvalid_reg;
    logic    m_tvalid_next;
    logic    out_load;
    logic    s1_adv;

    assign out_load      = !m_tvalid_reg || m_tready;
    assign s1_adv        = s1_valid_reg && out_load;
    assign s_tready      = !s1_valid_reg || out_load;
    assign s1_valid_next = s_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign m_tvalid_next = s1_adv ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    assign s1_next.mode    = in_mode;
    assign s1_next.first   = s_tuser[1];
    assign s1_next.newline = in_nl;
    assign s1_next.tab     = in_tab;
    assign s1_next.space   = (map_code == CODE_SPACE);
    assign s1_next.hit     = glyph_valid_reg[rd_addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_reg <= s1_next;
        end
    end

    // pen update
    logic [14:0] pen_x_reg;
    logic [14:0] pen_y_reg;
    logic [14:0] pen_x_next;
    logic [14:0] pen_y_next;
    logic [14:0] px0;
    logic [14:0] py0;
    logic [14:0] px1;
    logic [14:0] py1;
    logic [13:0] tab_step;
    logic [14:0] py_line;
    logic        wrap;
    logic        draw_next;
    logic signed [16:0] dx_next;
    logic signed [16:0] dy_next;

    assign px0      = s1_reg.first ? '0 : pen_x_reg;
    assign py0      = s1_reg.first ? '0 : pen_y_reg;
    assign tab_step = 14'(space_width_reg) * 14'(tab_size_reg);
    assign py_line  = sat_pen({1'b0, py0} + 16'(line_height_reg));
    assign wrap     = (max_line_reg != '0) && !s1_reg.space &&
                      (({1'b0, px0} + 16'(metric_rd_reg.adv)) >= {1'b0, max_line_reg});
    assign px1      = wrap ? '0 : px0;
    assign py1      = wrap ? py_line : py0;
    assign dx_next  = $signed({2'b00, px1}) + 17'(metric_rd_reg.xoff);
    assign dy_next  = $signed({2'b00, py1}) + 17'(metric_rd_reg.yoff);

    always_comb begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        draw_next  = 1'b0;
        if (s1_reg.mode == MODE_LAYOUT) begin
            if (s1_reg.newline) begin
                pen_x_next = '0;
                pen_y_next = py_line;
            end else if (s1_reg.tab) begin
                pen_x_next = sat_pen({1'b0, px0} + 16'(tab_step));
                pen_y_next = py0;
            end else if (s1_reg.hit) begin
                pen_x_next = sat_pen({1'b0, px1} + 16'(metric_rd_reg.adv));
                pen_y_next = py1;
                draw_next  = 1'b1;
            end else begin
                pen_x_next = px0;
                pen_y_next = py0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end else if (s1_adv) begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

    // output register
    logic [111:0] m_tdata_reg;
    logic         m_draw_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_draw_reg <= draw_next;
            if (draw_next) begin
                m_tdata_reg[81:0] <= {metric_rd_reg.page, rect_rd_reg.h, rect_rd_reg.w,
                                      rect_rd_reg.sy, rect_rd_reg.sx, dy_next, dx_next};
            end else begin
                m_tdata_reg[81:0] <= '0;
            end
            m_tdata_reg[111:82] <= {pen_y_next, pen_x_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_draw_reg;

    `BFL_ASSERT_IMP(a_nodraw_zero, aclk, aresetn,
        m_tvalid && !m_tuser, m_tdata[81:0] == '0)
    `BFL_ASSERT_NXT(a_stall_holds, aclk, aresetn,
        s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_reg))
    `BFL_ASSERT_NXT(a_load_keeps_pen, aclk, aresetn,
        s1_adv && (s1_reg.mode == MODE_LOAD), $stable(pen_x_reg) && $stable(pen_y_reg))

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the bitmap font text layout block
`timescale 1ns / 100ps

module testbench;
    import bfl_pkg::*;

    localparam int GLYPH_SLOTS = 128;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;

    // input item, fields from the top down as they sit in tuser/tdata
    typedef struct packed {
        logic              first;
        logic              mode;
        logic [3:0]        page;
        logic [9:0]        adv;
        logic signed [9:0] yoff;
        logic signed [9:0] xoff;
        logic [9:0]        h;
        logic [9:0]        w;
        logic [11:0]       sy;
        logic [11:0]       sx;
        logic [7:0]        code;
    } glyph_item_t;

    // one output transaction, laid out as {m_tuser, m_tdata}
    typedef struct packed {
        logic               draw;
        logic [14:0]        pen_y;
        logic [14:0]        pen_x;
        logic [3:0]         page;
        logic [9:0]         h;
        logic [9:0]         w;
        logic [11:0]        src_y;
        logic [11:0]        src_x;
        logic signed [16:0] dest_y;
        logic signed [16:0] dest_x;
    } placement_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [14:0]  cfg_data = '0;

    bitmap_font_text_layout #(
        .GLYPH_COUNT(GLYPH_SLOTS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // layout model state
    rect_t       glyph_rects [GLYPH_SLOTS];
    metric_t     glyph_metrics [GLYPH_SLOTS];
    bit          glyph_loaded [GLYPH_SLOTS];
    logic [9:0]  space_w;
    logic [14:0] pen_x;
    logic [14:0] pen_y;
    logic [9:0]  line_step;
    logic [3:0]  tab_count;
    logic [14:0] wrap_limit;

    glyph_item_t text_items [$];
    placement_t  placements_due [$];
    glyph_item_t cur_item;
    placement_t  want;
    placement_t  got;

    int  n_pushed = 0;
    int  n_accepted = 0;
    int  errors = 0;
    int  cycles = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  rx_hold = 1'b0;

    function automatic logic [14:0] pen_sum(input int a, input int b);
        int s;
        s = a + b;
        return (s > int'(PEN_MAX)) ? PEN_MAX : s[14:0];
    endfunction

    function automatic placement_t place_glyph(input glyph_item_t it);
        placement_t p;
        logic [7:0] c;
        metric_t    m;
        rect_t      r;
        int         dx;
        int         dy;
        p = '0;
        if (it.mode == MODE_LOAD) begin
            if (!it.code[7]) begin
                glyph_rects[it.code[6:0]] = {it.sx, it.sy, it.w, it.h};
                glyph_metrics[it.code[6:0]] = {it.xoff, it.yoff, it.adv, it.page};
                glyph_loaded[it.code[6:0]] = 1'b1;
                if (it.code == CODE_SPACE)
                    space_w = it.adv;
            end
        end else begin
            if (it.first) begin
                pen_x = '0;
                pen_y = '0;
            end
            if (it.code == CODE_NEWLINE) begin
                pen_x = '0;
                pen_y = pen_sum(int'(pen_y), int'(line_step));
            end else if (it.code == CODE_TAB) begin
                pen_x = pen_sum(int'(pen_x), int'(space_w) * int'(tab_count));
            end else begin
                c = (it.code < CODE_SPACE || it.code[7]) ? CODE_SPACE : it.code;
                if (glyph_loaded[c[6:0]]) begin
                    m = glyph_metrics[c[6:0]];
                    r = glyph_rects[c[6:0]];
                    if (wrap_limit != 0 && c != CODE_SPACE &&
                        int'(pen_x) + int'(m.adv) >= int'(wrap_limit)) begin
                        pen_x = '0;
                        pen_y = pen_sum(int'(pen_y), int'(line_step));
                    end
                    dx = int'(pen_x) + int'(m.xoff);
                    dy = int'(pen_y) + int'(m.yoff);
                    p.draw = 1'b1;
                    p.dest_x = dx[16:0];
                    p.dest_y = dy[16:0];
                    p.src_x = r.sx;
                    p.src_y = r.sy;
                    p.w = r.w;
                    p.h = r.h;
                    p.page = m.page;
                    pen_x = pen_sum(int'(pen_x), int'(m.adv));
                end
            end
        end
        p.pen_x = pen_x;
        p.pen_y = pen_y;
        return p;
    endfunction

    function automatic glyph_item_t load_item(input logic [7:0] code,
                                              input logic [11:0] sx, input logic [11:0] sy,
                                              input logic [9:0] w, input logic [9:0] h,
                                              input logic signed [9:0] xoff,
                                              input logic signed [9:0] yoff,
                                              input logic [9:0] adv, input logic [3:0] page);
        glyph_item_t it;
        it.first = 1'($urandom_range(0, 1));
        it.mode = MODE_LOAD;
        it.code = code;
        it.sx = sx;
        it.sy = sy;
        it.w = w;
        it.h = h;
        it.xoff = xoff;
        it.yoff = yoff;
        it.adv = adv;
        it.page = page;
        return it;
    endfunction

    // load with random rectangle, offsets and page
    function automatic glyph_item_t load_any(input logic [7:0] code, input logic [9:0] adv);
        return load_item(code, 12'($urandom), 12'($urandom), 10'($urandom), 10'($urandom),
                         10'($urandom), 10'($urandom), adv, 4'($urandom));
    endfunction

    function automatic glyph_item_t char_item(input logic [7:0] code, input logic first);
        glyph_item_t it;
        it = 98'({$urandom, $urandom, $urandom, $urandom});
        it.mode = MODE_LAYOUT;
        it.code = code;
        it.first = first;
        return it;
    endfunction

    function automatic glyph_item_t rand_load(input logic [7:0] code, input int adv_cap);
        logic [9:0] adv;
        adv = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, adv_cap));
        return load_any(code, adv);
    endfunction

    task automatic queue_item(input glyph_item_t it);
        text_items.insert(text_items.size(), it);
        n_pushed++;
    endtask

    task automatic font_load(input int adv_cap);
        int c;
        for (c = 32; c < 128; c++)
            queue_item(rand_load(c[7:0], adv_cap));
    endtask

    // mostly texts of printable characters, with glyph reloads mixed in
    task automatic random_phase(input int n, input int adv_cap);
        int made;
        int len;
        int k;
        int r;
        logic [7:0] code;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        code = 8'($urandom_range(128, 255));
                    else if (r < 3)
                        code = CODE_SPACE;
                    else
                        code = 8'($urandom_range(0, 127));
                    queue_item(rand_load(code, adv_cap));
                    made++;
                end
            end else begin
                len = $urandom_range(1, 30);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        code = CODE_NEWLINE;
                    else if (r < 14)
                        code = CODE_TAB;
                    else if (r < 20)
                        code = 8'($urandom_range(0, 31));
                    else if (r < 26)
                        code = 8'($urandom_range(128, 255));
                    else if (r < 36)
                        code = CODE_SPACE;
                    else
                        code = 8'($urandom_range(33, 127));
                    queue_item(char_item(code, (k == 0) ? ($urandom_range(0, 3) != 0)
                                                        : ($urandom_range(0, 49) == 0)));
                    made++;
                end
            end
        end
    endtask

    task automatic drain();
        while (n_accepted != n_pushed || placements_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LINE_HEIGHT: line_step = val[9:0];
            CFG_TAB_SIZE:    tab_count = val[3:0];
            CFG_MAX_LINE:    wrap_limit = val;
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                 input logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                placements_due.insert(placements_due.size(), place_glyph(cur_item));
                n_accepted++;
                tx_wait = tx_quiet ? 0 : $urandom_range(0, 3);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (text_items.size() != 0) begin
                    cur_item = text_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= {cur_item.first, cur_item.mode};
                    s_tdata <= {2'b00, cur_item.page, cur_item.adv, cur_item.yoff,
                                cur_item.xoff, cur_item.h, cur_item.w, cur_item.sy,
                                cur_item.sx, cur_item.code};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (placements_due.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = placements_due.pop_front();
                    compare_field("draw", 32'(want.draw), 32'(got.draw));
                    compare_field("dest_x", 32'(want.dest_x), 32'(got.dest_x));
                    compare_field("dest_y", 32'(want.dest_y), 32'(got.dest_y));
                    compare_field("src_x", 32'(want.src_x), 32'(got.src_x));
                    compare_field("src_y", 32'(want.src_y), 32'(got.src_y));
                    compare_field("rect_width", 32'(want.w), 32'(got.w));
                    compare_field("rect_height", 32'(want.h), 32'(got.h));
                    compare_field("page", 32'(want.page), 32'(got.page));
                    compare_field("pen_x", 32'(want.pen_x), 32'(got.pen_x));
                    compare_field("pen_y", 32'(want.pen_y), 32'(got.pen_y));
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 3);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // switches both sides between stalling and streaming; one long receiver hold-off
    initial begin
        bit held;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            repeat ($urandom_range(20, 200)) @(posedge aclk);
            tx_quiet <= ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            if (!held && n_accepted >= 300) begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
                held = 1'b1;
            end
        end
    end

    initial begin
        foreach (glyph_loaded[i])
            glyph_loaded[i] = 1'b0;
        space_w = SPACE_WIDTH_RST;
        tab_count = TAB_SIZE_RST;
        line_step = '0;
        wrap_limit = '0;
        pen_x = '0;
        pen_y = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration, empty glyph table first
        queue_item(char_item(8'd65, 1'b1));
        queue_item(char_item(CODE_SPACE, 1'b0));
        queue_item(char_item(CODE_TAB, 1'b0));
        queue_item(char_item(CODE_NEWLINE, 1'b0));
        queue_item(load_any(8'd200, 10'($urandom)));
        queue_item(load_any(8'd128, 10'($urandom)));
        queue_item(load_item(CODE_SPACE, 12'd0, 12'd0, 10'd0, 10'd0, 10'sd0, 10'sd0,
                             10'd7, 4'd0));
        queue_item(load_item(8'd65, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF, -10'sd512,
                             10'sd511, 10'h3FF, 4'hF));
        queue_item(load_item(8'd0, 12'd0, 12'd0, 10'd0, 10'd0, 10'sd511, -10'sd512,
                             10'd0, 4'd0));
        queue_item(load_any(8'd127, 10'd3));
        queue_item(char_item(8'd65, 1'b1));
        queue_item(char_item(8'd65, 1'b0));
        queue_item(char_item(8'd0, 1'b0));
        queue_item(char_item(8'd200, 1'b0));
        queue_item(char_item(8'd31, 1'b0));
        queue_item(char_item(8'd127, 1'b0));
        queue_item(char_item(CODE_TAB, 1'b0));
        queue_item(char_item(CODE_NEWLINE, 1'b0));
        queue_item(char_item(8'd65, 1'b1));
        queue_item(load_any(CODE_NEWLINE, 10'($urandom)));
        queue_item(char_item(CODE_NEWLINE, 1'b0));
        queue_item(load_any(CODE_TAB, 10'($urandom)));
        queue_item(char_item(CODE_TAB, 1'b0));
        queue_item(char_item(8'd255, 1'b0));
        font_load(20);
        random_phase(180, 20);
        drain();

        // largest steps, pen saturation
        write_reg(CFG_LINE_HEIGHT, 15'd1023);
        write_reg(CFG_TAB_SIZE, 15'd15);
        write_reg(CFG_MAX_LINE, 15'd0);
        queue_item(load_any(CODE_SPACE, 10'h3FF));
        queue_item(char_item(CODE_TAB, 1'b1));
        queue_item(char_item(CODE_TAB, 1'b0));
        queue_item(char_item(CODE_TAB, 1'b0));
        queue_item(char_item(8'd65, 1'b0));
        queue_item(char_item(CODE_NEWLINE, 1'b0));
        random_phase(220, 1023);
        drain();

        write_reg(CFG_LINE_HEIGHT, 15'd0);
        write_reg(CFG_TAB_SIZE, 15'd0);
        write_reg(CFG_MAX_LINE, 15'h7FFF);
        random_phase(200, 1023);
        drain();

        // short lines, frequent wrapping
        write_reg(CFG_LINE_HEIGHT, 15'($urandom_range(1, 40)));
        write_reg(CFG_TAB_SIZE, 15'($urandom_range(1, 15)));
        write_reg(CFG_MAX_LINE, 15'($urandom_range(64, 600)));
        font_load(40);
        random_phase(200, 40);
        drain();

        write_reg(CFG_LINE_HEIGHT, 15'($urandom_range(0, 1023)));
        write_reg(CFG_MAX_LINE, 15'd1);
        random_phase(120, 40);
        drain();

        write_reg(CFG_LINE_HEIGHT, 15'($urandom_range(0, 1023)));
        write_reg(CFG_TAB_SIZE, 15'($urandom_range(0, 15)));
        write_reg(CFG_MAX_LINE, 15'($urandom_range(0, 32767)));
        random_phase(100, 1023);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
